// ===== design/aepf_pkg.sv =====
// aepf_pkg: shared types, character constants and helpers for the
// anchored entry pattern filter. No dependencies.

package aepf_pkg;

  // item kind carried in the mode field
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  // anchor characters
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  // control sent from the line controller to every cell of the chain
  typedef struct packed {
    logic load_clear;  // new pattern starts: drop stored bytes and cell states
    logic load_write;  // store one pattern byte in the first free cell
    logic match_en;    // headword byte: advance the shift-and chain
    logic first;       // byte is the first of its line
    logic start_ok;    // cell zero may start a match on this byte
    logic cell_clear;  // drop all partial matches
  } chain_ctrl_t;

  // summary returned by the chain
  typedef struct packed {
    logic empty;        // no pattern byte stored
    logic full;         // every cell holds a pattern byte
    logic tail_active;  // the last stored cell holds a complete match
  } chain_stat_t;

  // space, tab, LF, VT, FF and CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

// ===== design/aepf_if.sv =====
// aepf_if: request and result channel interfaces of the pattern filter.
// Depends on nothing; used by the top level.

interface aepf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, mode, text_char, last, input ready);
  modport sink (input valid, mode, text_char, last, output ready);
endinterface

interface aepf_out_if;
  logic valid;
  logic ready;
  logic print_line;
  logic entry_head;
  logic pattern_overflow;

  modport source (output valid, print_line, entry_head, pattern_overflow, input ready);
  modport sink (input valid, print_line, entry_head, pattern_overflow, output ready);
endinterface

// ===== design/aepf_cell.sv =====
// aepf_cell: one position of the shift-and chain; holds a pattern byte,
// its used bit and its match bit. Depends on aepf_pkg.

module aepf_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  aepf_pkg::chain_ctrl_t ctrl,
  input  logic [7:0]           text_char,
  input  logic                 prev_active,  // neighbour match bit, already gated
  input  logic                 prev_used,    // neighbour used bit, already gated
  input  logic                 next_used,
  output logic                 active,
  output logic                 used,
  output logic                 tail_hit
);

  logic [7:0] pattern_byte;
  logic       used_eff;
  logic       write_here;

  // this cell is the first free one when its neighbour is taken
  assign used_eff   = used & ~ctrl.load_clear;
  assign write_here = ctrl.load_write & prev_used & ~used_eff;

  // pattern byte storage
  always_ff @(posedge clk) begin
    if (write_here) begin
      pattern_byte <= text_char;
    end
  end

  // used bit
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (write_here) begin
      used <= 1'b1;
    end else if (ctrl.load_clear) begin
      used <= 1'b0;
    end
  end

  // match bit takes the neighbour's bit when the byte agrees
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.match_en) begin
      active <= prev_active & used & (pattern_byte == text_char);
    end else if (ctrl.cell_clear) begin
      active <= 1'b0;
    end
  end

  // last stored cell reports a complete match
  assign tail_hit = active & used & ~next_used;

endmodule

// ===== design/aepf_chain.sv =====
// aepf_chain: row of aepf_cell instances wired neighbour to neighbour,
// with the chain summary. Depends on aepf_pkg and aepf_cell.

module aepf_chain #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aepf_pkg::chain_ctrl_t ctrl,
  input  logic [7:0]            text_char,
  output aepf_pkg::chain_stat_t stat
);

  logic [PATTERN_MAX-1:0] active;
  logic [PATTERN_MAX-1:0] used;
  logic [PATTERN_MAX-1:0] tail_hit;
  logic [PATTERN_MAX-1:0] link_active;
  logic [PATTERN_MAX-1:0] link_used;
  logic [PATTERN_MAX-1:0] link_next;

  // links between neighbours
  assign link_active[0] = ctrl.start_ok;
  assign link_used[0]   = 1'b1;
  assign link_next[PATTERN_MAX-1] = 1'b0;

  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_link
    assign link_active[k] = active[k-1] & ~ctrl.first;
    assign link_used[k]   = used[k-1] & ~ctrl.load_clear;
    assign link_next[k-1] = used[k];
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    aepf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .text_char   (text_char),
      .prev_active (link_active[k]),
      .prev_used   (link_used[k]),
      .next_used   (link_next[k]),
      .active      (active[k]),
      .used        (used[k]),
      .tail_hit    (tail_hit[k])
    );
  end

  // summary
  assign stat.empty       = ~used[0];
  assign stat.full        = used[PATTERN_MAX-1];
  assign stat.tail_active = |tail_hit;

endmodule

// ===== design/anchored_entry_pattern_filter.sv =====
// anchored_entry_pattern_filter: top level with line and entry control and
// the result register. Depends on aepf_pkg, aepf_if and aepf_chain.

// Load a pattern with mode 0 requests (last on the final byte; a leading '^'
// anchors to the line start, a trailing '$' to the line end), then stream
// dictionary bytes with mode 1, one request per line byte and a request with
// last set for each newline. The block takes one request every cycle: each
// byte is compared against all PATTERN_MAX pattern positions at once in a row
// of cells that hand their match bit to the next cell, so there is no
// per-byte iteration. The result of a newline sits in the output register
// from the cycle after that newline is taken. Requests keep flowing while the
// sink takes results as they come; while a result waits on a stalled sink no
// request is taken. A pattern longer than PATTERN_MAX bytes is flagged as
// overflowed and never matches a headword line.

module anchored_entry_pattern_filter #(
  parameter int PATTERN_MAX = 64
) (
  input logic     clk,
  input logic     rst,
  aepf_in_if.sink   item,
  aepf_out_if.source report
);

  aepf_pkg::chain_ctrl_t ctrl;
  aepf_pkg::chain_stat_t stat;

  logic loading;
  logic anchor_start;
  logic anchor_end;
  logic overflow_flag;
  logic at_line_start;
  logic line_is_head;
  logic found_in_line;
  logic match_pending;
  logic entry_matched;
  logic out_valid;
  logic out_print;
  logic out_head;
  logic out_overflow;

  logic accept;
  logic is_load;
  logic text_byte;
  logic newline;
  logic load_start;
  logic caret_skip;
  logic dollar_end;
  logic store_full;
  logic store_byte;
  logic overflow_set;
  logic head_now;
  logic head_at_end;
  logic found_eff;
  logic line_ok;

  // request handshake
  assign item.ready = ~out_valid | report.ready;
  assign accept     = item.valid & item.ready;

  // request decode
  assign is_load   = accept & (item.mode == aepf_pkg::MODE_PATTERN);
  assign text_byte = accept & (item.mode == aepf_pkg::MODE_TEXT) & ~item.last;
  assign newline   = accept & (item.mode == aepf_pkg::MODE_TEXT) & item.last;

  // pattern load decisions
  assign load_start   = is_load & ~loading;
  assign caret_skip   = load_start & (item.text_char == aepf_pkg::CHAR_CARET);
  assign dollar_end   = is_load & ~caret_skip & item.last
                        & (item.text_char == aepf_pkg::CHAR_DOLLAR);
  assign store_full   = stat.full & ~load_start;
  assign store_byte   = is_load & ~caret_skip & ~dollar_end;
  assign overflow_set = store_byte & store_full;

  // headword tracking
  assign head_now    = at_line_start ? ~aepf_pkg::is_blank(item.text_char) : line_is_head;
  assign head_at_end = ~at_line_start & line_is_head;

  // chain control
  assign ctrl.load_clear = load_start;
  assign ctrl.load_write = store_byte & ~store_full;
  assign ctrl.match_en   = text_byte & head_now;
  assign ctrl.first      = text_byte & at_line_start;
  assign ctrl.start_ok   = ~anchor_start | at_line_start;
  assign ctrl.cell_clear = load_start | newline | (text_byte & at_line_start);

  aepf_chain #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .text_char (item.text_char),
    .stat      (stat)
  );

  // the chain shows last cycle's byte now; fold its end check into the flag
  assign found_eff = found_in_line
                     | (match_pending & ~anchor_end & (stat.empty | stat.tail_active));

  // verdict for the headword line being closed
  always_comb begin
    if (overflow_flag) begin
      line_ok = 1'b0;
    end else if (anchor_end) begin
      line_ok = stat.empty ? ~anchor_start : stat.tail_active;
    end else begin
      line_ok = found_eff;
    end
  end

  // pattern load state
  always_ff @(posedge clk) begin
    if (rst) begin
      loading       <= 1'b0;
      anchor_start  <= 1'b0;
      anchor_end    <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (is_load) begin
      loading <= ~item.last;
      if (load_start) begin
        anchor_start  <= caret_skip;
        anchor_end    <= dollar_end;
        overflow_flag <= overflow_set;
      end else begin
        anchor_end    <= anchor_end | dollar_end;
        overflow_flag <= overflow_flag | overflow_set;
      end
    end
  end

  // line and entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      line_is_head  <= 1'b0;
      found_in_line <= 1'b0;
      match_pending <= 1'b0;
      entry_matched <= 1'b0;
    end else begin
      match_pending <= ctrl.match_en;
      if (text_byte) begin
        at_line_start <= 1'b0;
        line_is_head  <= head_now;
        found_in_line <= at_line_start ? 1'b0 : found_eff;
      end else if (newline) begin
        at_line_start <= 1'b1;
        line_is_head  <= 1'b0;
        found_in_line <= 1'b0;
        if (head_at_end) begin
          entry_matched <= line_ok;
        end
      end else begin
        found_in_line <= found_eff;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (newline) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (newline) begin
      out_print    <= head_at_end ? line_ok : entry_matched;
      out_head     <= head_at_end;
      out_overflow <= overflow_flag;
    end
  end

  assign report.valid            = out_valid;
  assign report.print_line       = out_print;
  assign report.entry_head       = out_head;
  assign report.pattern_overflow = out_overflow;

`ifndef SYNTHESIS
  // a pending end check always follows a headword byte
  a_pending_after_byte: assert property (@(posedge clk) disable iff (rst)
    match_pending |-> $past(text_byte))
    else $error("end check pending without a headword byte");

  // overflow only arises with every cell taken
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> stat.full)
    else $error("overflow flagged while the chain has room");

  // an overflowed pattern never matches a headword line
  a_overflow_no_print: assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.entry_head && report.pattern_overflow) |-> !report.print_line)
    else $error("overflowed pattern reported a match");

  // between lines no headword or match state survives
  a_line_start_clean: assert property (@(posedge clk) disable iff (rst)
    at_line_start |-> (!line_is_head && !found_in_line))
    else $error("line state left over at line start");
`endif

endmodule

// ===== tb/anchored_entry_pattern_filter_test.sv =====
`timescale 1ns / 1ps
// anchored_entry_pattern_filter_test: self-checking bench for the pattern filter.
// Depends on aepf_pkg, aepf_if and the filter top level; a built-in line predictor
// checks every line verdict against requests driven with random idling on both sides.

module anchored_entry_pattern_filter_test;

  localparam int PAT_CAP = 64;
  localparam int TOTAL_ITEMS = 1800;
  localparam int TAIL_ITEMS = 150;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    bit         mode;
    logic [7:0] ch;
    bit         last;
  } filter_req_t;

  typedef struct {
    bit print_line;
    bit entry_head;
    bit pattern_overflow;
  } line_verdict_t;

  logic clk;
  logic rst;

  aepf_in_if  item_ch ();
  aepf_out_if report_ch ();

  anchored_entry_pattern_filter #(.PATTERN_MAX(PAT_CAP)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .report (report_ch)
  );

  filter_req_t   pending_reqs[$];
  line_verdict_t line_verdicts[$];
  int            queued_total = 0;
  int            mismatches = 0;

  // predictor state, mirrors the filter after reset
  logic [7:0]         pat_bytes[PAT_CAP];
  logic [PAT_CAP-1:0] cells = '0;
  int                 pat_len = 0;
  bit                 anc_start = 0;
  bit                 anc_end = 0;
  bit                 loading = 0;
  bit                 ovf = 0;
  bit                 line_start = 1;
  bit                 head_line = 0;
  bit                 seen_match = 0;
  bit                 entry_hit = 0;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic bit blank_byte(input logic [7:0] c);
    return (c == aepf_pkg::CHAR_SPACE) ||
           ((c >= aepf_pkg::CHAR_TAB) && (c <= aepf_pkg::CHAR_CR));
  endfunction

  // advance the predictor by one accepted request
  task automatic apply_request(input bit m, input logic [7:0] c, input bit fin);
    bit            first_byte;
    bit            prev;
    bit            hit;
    int            k;
    line_verdict_t v;
    if (m == aepf_pkg::MODE_PATTERN) begin
      if (!loading) begin
        pat_len   = 0;
        anc_start = 0;
        anc_end   = 0;
        ovf       = 0;
        cells     = '0;
      end
      if (!loading && c == aepf_pkg::CHAR_CARET) begin
        anc_start = 1;
      end else if (fin && c == aepf_pkg::CHAR_DOLLAR) begin
        anc_end = 1;
      end else if (pat_len < PAT_CAP) begin
        pat_bytes[pat_len] = c;
        pat_len++;
      end else begin
        ovf = 1;
      end
      loading = !fin;
    end else if (!fin) begin
      first_byte = line_start;
      if (first_byte) begin
        head_line  = !blank_byte(c);
        line_start = 0;
        seen_match = 0;
        cells      = '0;
      end
      if (head_line) begin
        // shift-and step, highest cell first so each reads the old neighbour
        for (k = pat_len - 1; k >= 0; k--) begin
          prev = (k == 0) ? (!anc_start || first_byte) : cells[k-1];
          cells[k] = prev && (pat_bytes[k] == c);
        end
        if (!anc_end && (pat_len == 0 || cells[pat_len-1]))
          seen_match = 1;
      end
    end else begin
      if (line_start)
        head_line = 0;
      if (head_line) begin
        if (ovf)
          hit = 0;
        else if (anc_end)
          hit = (pat_len == 0) ? !anc_start : cells[pat_len-1];
        else
          hit = seen_match;
        entry_hit = hit;
      end
      v.print_line       = entry_hit;
      v.entry_head       = head_line;
      v.pattern_overflow = ovf;
      line_verdicts.push_back(v);
      line_start = 1;
      head_line  = 0;
      seen_match = 0;
      cells      = '0;
    end
  endtask

  task automatic queue_req(input bit m, input logic [7:0] c, input bit fin);
    filter_req_t r;
    r.mode = m;
    r.ch   = c;
    r.last = fin;
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  task automatic queue_pattern_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      queue_req(aepf_pkg::MODE_PATTERN, s[i], i == s.len() - 1);
  endtask

  task automatic queue_line_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      queue_req(aepf_pkg::MODE_TEXT, s[i], 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'h0A, 1'b1);
  endtask

  // text bytes lean on a tiny alphabet so that matches are common
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)
      return "a";
    else if (r < 80)
      return "b";
    else if (r < 85)
      return aepf_pkg::CHAR_CARET;
    else if (r < 88)
      return aepf_pkg::CHAR_DOLLAR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return aepf_pkg::CHAR_SPACE;
      1: return aepf_pkg::CHAR_TAB;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return aepf_pkg::CHAR_CR;
    endcase
  endfunction

  // one dictionary line: headword or continuation, sometimes long
  task automatic queue_random_line();
    bit         head;
    int         len;
    int         i;
    logic [7:0] b;
    head = ($urandom_range(9) < 7);
    len  = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 10);
    if (head) begin
      b = pick_text_byte();
      while (blank_byte(b))
        b = pick_text_byte();
      queue_req(aepf_pkg::MODE_TEXT, b, 1'b0);
    end else if (len > 0) begin
      queue_req(aepf_pkg::MODE_TEXT, pick_blank(), 1'b0);
    end
    for (i = 1; i < len; i++)
      queue_req(aepf_pkg::MODE_TEXT, pick_text_byte(), 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'($urandom_range(255)), 1'b1);
  endtask

  // pattern with random anchors, now and then interrupted by text lines
  task automatic queue_random_pattern();
    logic [7:0] pat[$];
    int         len;
    int         i;
    bit         caret;
    bit         dollar;
    caret  = ($urandom_range(2) == 0);
    dollar = ($urandom_range(2) == 0);
    len    = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
    if (len == 0 && !caret && !dollar)
      len = 1;
    if (caret)
      pat.push_back(aepf_pkg::CHAR_CARET);
    for (i = 0; i < len; i++)
      pat.push_back(pick_text_byte());
    if (dollar)
      pat.push_back(aepf_pkg::CHAR_DOLLAR);
    for (i = 0; i < pat.size(); i++) begin
      queue_req(aepf_pkg::MODE_PATTERN, pat[i], i == pat.size() - 1);
      if (i < pat.size() - 1 && $urandom_range(9) == 0)
        queue_random_line();
    end
  endtask

  task automatic report_field(input string name, input bit want, input bit got);
    if (want !== got) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  int src_gap = 0;
  int src_idle_pct = 0;
  int src_cycles = 0;

  always @(posedge clk) begin : drive_requests
    filter_req_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        apply_request(item_ch.mode, item_ch.text_char, item_ch.last);
      src_cycles++;
      if (src_cycles % 64 == 0)
        src_idle_pct = $urandom_range(3) * 10;
      if (!item_ch.valid || item_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > TAIL_ITEMS &&
                     $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(1, 12) - 1;
          item_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          item_ch.valid     <= 1'b1;
          item_ch.mode      <= nxt.mode;
          item_ch.text_char <= nxt.ch;
          item_ch.last      <= nxt.last;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor with random back-pressure
  int snk_gap = 0;
  int snk_idle_pct = 0;
  int snk_cycles = 0;

  always @(posedge clk) begin : check_verdicts
    line_verdict_t want;
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (line_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict, expected none actual print=%0b head=%0b ovf=%0b",
                   $time, report_ch.print_line, report_ch.entry_head,
                   report_ch.pattern_overflow);
          mismatches++;
        end else begin
          want = line_verdicts.pop_front();
          report_field("print_line", want.print_line, report_ch.print_line);
          report_field("entry_head", want.entry_head, report_ch.entry_head);
          report_field("pattern_overflow", want.pattern_overflow,
                       report_ch.pattern_overflow);
        end
      end
      snk_cycles++;
      if (snk_cycles % 64 == 0)
        snk_idle_pct = $urandom_range(3) * 10;
      if (snk_gap > 0) begin
        snk_gap--;
        report_ch.ready <= 1'b0;
      end else if (pending_reqs.size() > TAIL_ITEMS &&
                   $urandom_range(99) < snk_idle_pct) begin
        snk_gap = $urandom_range(1, 12) - 1;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int          i;
    logic [7:0]  ws[6];
    item_ch.valid     = 1'b0;
    item_ch.mode      = aepf_pkg::MODE_PATTERN;
    item_ch.text_char = 8'h00;
    item_ch.last      = 1'b0;
    report_ch.ready   = 1'b0;
    rst               = 1'b1;

    // both anchors: whole line, plus continuation and empty line
    queue_pattern_str("^ab$");
    queue_line_str("ab");
    queue_line_str(" xab");
    queue_line_str("");
    queue_line_str("abc");
    // start anchor, end anchor, unanchored
    queue_pattern_str("^ab");
    queue_line_str("abx");
    queue_line_str("xab");
    queue_pattern_str("ab$");
    queue_line_str("xab");
    queue_line_str("abx");
    queue_pattern_str("ab");
    queue_line_str("xaby");
    // caret and dollar in the middle are ordinary bytes
    queue_pattern_str("a^$b");
    queue_line_str("za^$b");
    // empty stored pattern with each anchor combination
    queue_pattern_str("^");
    queue_line_str("zz");
    queue_pattern_str("^$");
    queue_line_str("zz");
    queue_pattern_str("$");
    queue_line_str("zz");
    // byte extremes
    queue_req(aepf_pkg::MODE_PATTERN, 8'hFF, 1'b0);
    queue_req(aepf_pkg::MODE_PATTERN, 8'h00, 1'b1);
    queue_req(aepf_pkg::MODE_TEXT, 8'hFF, 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'h00, 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'hFF, 1'b1);
    // text lines arrive while the pattern is still loading
    queue_pattern_str("ab");
    pending_reqs[pending_reqs.size()-1].last = 1'b0;
    queue_line_str("zab");
    queue_pattern_str("c");
    queue_line_str("abc");
    // every whitespace byte opens a continuation line
    ws = '{aepf_pkg::CHAR_SPACE, aepf_pkg::CHAR_TAB, 8'h0A, 8'h0B, 8'h0C,
           aepf_pkg::CHAR_CR};
    for (i = 0; i < 6; i++) begin
      queue_req(aepf_pkg::MODE_TEXT, ws[i], 1'b0);
      queue_line_str("abc");
    end
    // overflow, then a full store closed by a dollar
    for (i = 0; i <= PAT_CAP; i++)
      queue_req(aepf_pkg::MODE_PATTERN, "a", i == PAT_CAP);
    queue_line_str("aaaa");
    for (i = 0; i < PAT_CAP; i++)
      queue_req(aepf_pkg::MODE_PATTERN, "a", 1'b0);
    queue_req(aepf_pkg::MODE_PATTERN, aepf_pkg::CHAR_DOLLAR, 1'b1);
    for (i = 0; i < PAT_CAP + 2; i++)
      queue_req(aepf_pkg::MODE_TEXT, "a", 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'h0A, 1'b1);
    // long headword line, never split
    queue_pattern_str("ba");
    for (i = 0; i < 200; i++)
      queue_req(aepf_pkg::MODE_TEXT, (i == 190) ? "b" : "a", 1'b0);
    queue_req(aepf_pkg::MODE_TEXT, 8'h0A, 1'b1);

    // random episodes: a pattern, then a handful of lines
    while (queued_total < TOTAL_ITEMS) begin
      queue_random_pattern();
      repeat ($urandom_range(2, 8))
        queue_random_line();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // wait for every request and every verdict, then let the pipe drain
    @(negedge clk);
    while (pending_reqs.size() != 0 || item_ch.valid || line_verdicts.size() != 0)
      @(negedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== anchored_entry_pattern_filter.f =====
design/aepf_pkg.sv
design/aepf_if.sv
design/aepf_cell.sv
design/aepf_chain.sv
design/anchored_entry_pattern_filter.sv
tb/anchored_entry_pattern_filter_test.sv
